[design/pol_pkg.sv]
package pol_pkg;

    localparam int DEPTH  = 16;
    localparam int WIDTH  = 32;
    localparam int FUNC_W = 2;
    localparam int POS_W  = 5;
    localparam int STAT_W = 2;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    // Wide enough for position and count + 1 without overflow.
    localparam int CMP_W  = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_DELETE = 2'd1,
        FUNC_READ   = 2'd2
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic             ins;
        logic             del;
        logic [IDX_W-1:0] slot;
        logic [WIDTH-1:0] value;
    } cell_cmd_t;

endpackage

[design/pol_cells.sv]
module pol_cells (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pol_pkg::cell_cmd_t            cmd,
    input  logic [pol_pkg::IDX_W-1:0]     rd_slot,
    output logic [pol_pkg::WIDTH-1:0]     rd_data,
    output logic [pol_pkg::CNT_W-1:0]     count
);

    logic [pol_pkg::WIDTH-1:0] entry_reg [pol_pkg::DEPTH];
    logic [pol_pkg::CNT_W-1:0] count_reg;
    logic [pol_pkg::CNT_W-1:0] count_next;

    // Each cell picks hold, load or a neighbour's value from its own compare with the slot.
    for (genvar k = 0; k < pol_pkg::DEPTH; k++) begin : g_cell
        logic [pol_pkg::WIDTH-1:0] prev_val;
        logic [pol_pkg::WIDTH-1:0] succ_val;
        logic                      at_slot;
        logic                      past_slot;

        if (k == 0) begin : g_first
            assign prev_val = entry_reg[k];
        end else begin : g_prev
            assign prev_val = entry_reg[k-1];
        end

        if (k == pol_pkg::DEPTH - 1) begin : g_last
            assign succ_val = entry_reg[k];
        end else begin : g_succ
            assign succ_val = entry_reg[k+1];
        end

        assign at_slot   = (pol_pkg::IDX_W'(k) == cmd.slot);
        assign past_slot = (pol_pkg::IDX_W'(k) > cmd.slot);

        always_ff @(posedge clk)
        begin
            if (cmd.ins)
            begin
                if (at_slot)
                begin
                    entry_reg[k] <= cmd.value;
                end
                else if (past_slot)
                begin
                    entry_reg[k] <= prev_val;
                end
            end
            else if (cmd.del && (at_slot || past_slot))
            begin
                entry_reg[k] <= succ_val;
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins)
        begin
            count_next = count_reg + pol_pkg::CNT_W'(1);
        end
        else if (cmd.del)
        begin
            count_next = count_reg - pol_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign rd_data = entry_reg[rd_slot];
    assign count   = count_reg;

endmodule

[design/positional_ordered_list_unit.sv]
// Bounded list of up to sixteen 32-bit values addressed by 1-based position, taking
// insert, delete and read transactions. One transaction is accepted every clock cycle
// unless in_stall is high (a result held by out_stall blocks the input register). The
// transaction waits in the input register, then completes in a single pass through the
// row of list cells (each cell shifting, holding or loading on its own position compare)
// into the result register. Every transaction yields exactly one result with a status
// (ok, position out of range, list full), the entry count after the operation and,
// for a successful read, the value found. The list is empty after reset.
module positional_ordered_list_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [pol_pkg::FUNC_W-1:0]     func,
    input  logic [pol_pkg::POS_W-1:0]      position,
    input  logic signed [pol_pkg::WIDTH-1:0] value_in,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [pol_pkg::WIDTH-1:0] value_out,
    output logic [pol_pkg::STAT_W-1:0]     status,
    output logic [pol_pkg::CNT_W-1:0]      fill_count
);

    logic                        s1_valid_reg;
    logic [pol_pkg::FUNC_W-1:0]  func_reg;
    logic [pol_pkg::POS_W-1:0]   position_reg;
    logic [pol_pkg::WIDTH-1:0]   value_in_reg;

    logic                        out_valid_reg;
    logic [pol_pkg::WIDTH-1:0]   value_out_reg;
    logic [pol_pkg::STAT_W-1:0]  status_reg;
    logic [pol_pkg::CNT_W-1:0]   fill_count_reg;

    logic [pol_pkg::WIDTH-1:0]   value_out_next;
    pol_pkg::status_t            status_next;
    logic [pol_pkg::CNT_W-1:0]   fill_count_next;

    logic                        s1_adv;
    logic                        fire;
    logic [pol_pkg::CMP_W-1:0]   pos_ext;
    logic [pol_pkg::CMP_W-1:0]   cnt_ext;
    logic                        ins_ok_pos;
    logic                        acc_ok_pos;
    logic                        full;
    logic [pol_pkg::POS_W-1:0]   slot_wide;
    logic [pol_pkg::IDX_W-1:0]   slot;
    logic [pol_pkg::WIDTH-1:0]   rd_data;
    logic [pol_pkg::CNT_W-1:0]   count;
    pol_pkg::cell_cmd_t          cmd;

    assign s1_adv   = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !s1_adv;
    assign fire     = s1_valid_reg && s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            func_reg     <= func;
            position_reg <= position;
            value_in_reg <= value_in;
        end
    end

    assign pos_ext    = pol_pkg::CMP_W'(position_reg);
    assign cnt_ext    = pol_pkg::CMP_W'(count);
    assign ins_ok_pos = (position_reg != '0) && (pos_ext <= cnt_ext + pol_pkg::CMP_W'(1));
    assign acc_ok_pos = (position_reg != '0) && (pos_ext <= cnt_ext);
    assign full       = (count == pol_pkg::CNT_W'(pol_pkg::DEPTH));
    assign slot_wide  = position_reg - pol_pkg::POS_W'(1);
    // Only used when the position is in range, so the low bits address a real cell.
    assign slot       = slot_wide[pol_pkg::IDX_W-1:0];

    always_comb
    begin
        cmd.ins         = 1'b0;
        cmd.del         = 1'b0;
        cmd.slot        = slot;
        cmd.value       = value_in_reg;
        status_next     = pol_pkg::STATUS_RANGE;
        value_out_next  = '0;
        fill_count_next = count;
        case (pol_pkg::func_t'(func_reg))
            pol_pkg::FUNC_INSERT:
            begin
                if (ins_ok_pos)
                begin
                    if (full)
                    begin
                        status_next = pol_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        status_next     = pol_pkg::STATUS_OK;
                        cmd.ins         = fire;
                        fill_count_next = count + pol_pkg::CNT_W'(1);
                    end
                end
            end
            pol_pkg::FUNC_DELETE:
            begin
                if (acc_ok_pos)
                begin
                    status_next     = pol_pkg::STATUS_OK;
                    cmd.del         = fire;
                    fill_count_next = count - pol_pkg::CNT_W'(1);
                end
            end
            pol_pkg::FUNC_READ:
            begin
                if (acc_ok_pos)
                begin
                    status_next    = pol_pkg::STATUS_OK;
                    value_out_next = rd_data;
                end
            end
            default:
            begin
                status_next = pol_pkg::STATUS_RANGE;
            end
        endcase
    end

    pol_cells u_cells (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .rd_slot (slot),
        .rd_data (rd_data),
        .count   (count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            value_out_reg  <= value_out_next;
            status_reg     <= status_next;
            fill_count_reg <= fill_count_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign value_out  = value_out_reg;
    assign status     = status_reg;
    assign fill_count = fill_count_reg;

endmodule

[design/pol_checker.sv]
module pol_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic signed [pol_pkg::WIDTH-1:0] value_out,
    input logic [pol_pkg::STAT_W-1:0]       status,
    input logic [pol_pkg::CNT_W-1:0]        fill_count
);

    // A result held back by the receiver stays put until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value_out) && $stable(status)
            && $stable(fill_count))
        else $error("result changed while stalled");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> fill_count <= pol_pkg::CNT_W'(pol_pkg::DEPTH))
        else $error("fill count beyond list depth");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == pol_pkg::STATUS_FULL
            |-> fill_count == pol_pkg::CNT_W'(pol_pkg::DEPTH))
        else $error("full status with room left");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != pol_pkg::STATUS_OK |-> value_out == '0)
        else $error("value returned on a failed transaction");

endmodule

bind positional_ordered_list_unit pol_checker u_pol_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .value_out  (value_out),
    .status     (status),
    .fill_count (fill_count)
);
